FILE: rtl/core/footswitch_bypass_relay_controller_core_assert.svh
// Assertion macros shared by the footswitch bypass relay controller core.
// Each macro is a clocked property that is disabled while reset is low.
`ifndef FOOTSWITCH_BYPASS_RELAY_CONTROLLER_CORE_ASSERT_SVH
`define FOOTSWITCH_BYPASS_RELAY_CONTROLLER_CORE_ASSERT_SVH

// The antecedent implies the consequent in the same cycle.
`define FBRC_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fbrc assertion failed");

// The antecedent implies the consequent in the next cycle.
`define FBRC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fbrc assertion failed");

`endif

FILE: rtl/core/fbrc_pkg.sv
// Package for the footswitch bypass relay controller core.
// Holds phase and register index codes and the structs passed between modules.
package fbrc_pkg;

  localparam int unsigned CfgW    = 8;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [1:0] {
    PH_STARTUP = 2'd0,
    PH_WAIT    = 2'd1,
    PH_PHOTO   = 2'd2,
    PH_DRIVE   = 2'd3
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PHOTO_TICKS    = 2'd0,
    CFG_PULSE_TICKS    = 2'd1,
    CFG_DEBOUNCE_TICKS = 2'd2,
    CFG_LATCHING_RELAY = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [CfgW-1:0] photo_ticks;
    logic [CfgW-1:0] pulse_ticks;
    logic [CfgW-1:0] debounce_ticks;
    logic            latching_relay;
  } cfg_t;

  typedef struct packed {
    logic set_pin;
    logic reset_pin;
    logic hold_pin;
    logic coupler_pin;
    logic led_pin;
  } pins_t;

  typedef struct packed {
    pins_t pins;
    logic  busy;
  } res_t;

  localparam logic [CfgW-1:0] PhotoTicksRst    = 8'd5;
  localparam logic [CfgW-1:0] PulseTicksRst    = 8'd5;
  localparam logic [CfgW-1:0] DebounceTicksRst = 8'd10;
  localparam logic [1:0]      CountSat         = 2'd2;

endpackage

FILE: rtl/core/fbrc_step.sv
// Per-tick engine of the footswitch bypass relay controller: phase, timer,
// debounce counters and pin state, advanced once per beat. Uses fbrc_pkg.
module fbrc_step #(
  parameter int unsigned TIMER_WIDTH = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            foot_i,
  input  logic            mode_i,
  input  fbrc_pkg::cfg_t  cfg_i,
  output fbrc_pkg::res_t  res_o
);

  fbrc_pkg::phase_e       phase_q, phase_d;
  logic [TIMER_WIDTH-1:0] tmr_q, tmr_d;
  logic                   first_q, first_d;
  logic [1:0]             press_q, press_d;
  logic [1:0]             rel_q, rel_d;
  logic                   effect_q, effect_d;
  fbrc_pkg::pins_t        pins_q, pins_d;

  always_comb begin
    logic                   last;
    logic                   do_toggle;
    logic                   do_drive;
    logic                   do_finish;
    logic                   do_sample;
    logic [TIMER_WIDTH-1:0] photo_ld;
    logic [TIMER_WIDTH-1:0] pulse_ld;

    phase_d   = phase_q;
    tmr_d     = tmr_q;
    first_d   = first_q;
    press_d   = press_q;
    rel_d     = rel_q;
    effect_d  = effect_q;
    pins_d    = pins_q;
    do_toggle = 1'b0;
    do_drive  = 1'b0;
    do_finish = 1'b0;
    do_sample = 1'b0;
    last      = (tmr_q <= TIMER_WIDTH'(1));
    photo_ld  = TIMER_WIDTH'(cfg_i.photo_ticks);
    pulse_ld  = TIMER_WIDTH'(cfg_i.pulse_ticks);

    case (phase_q)
      fbrc_pkg::PH_STARTUP: begin
        if (!cfg_i.latching_relay || last) begin
          pins_d.reset_pin = 1'b0;
          do_sample        = 1'b1;
        end else begin
          tmr_d = tmr_q - TIMER_WIDTH'(1);
        end
      end
      fbrc_pkg::PH_WAIT: begin
        if (last) begin
          // Act only when both samples agree.
          if (foot_i == first_q) begin
            if (foot_i) begin
              press_d = 2'd0;
              if (rel_q == 2'd0 && !mode_i) begin
                rel_d     = 2'd1;
                do_toggle = 1'b1;
              end else begin
                rel_d = fbrc_pkg::CountSat;
              end
            end else begin
              rel_d = 2'd0;
              if (press_q == 2'd0) begin
                press_d   = 2'd1;
                do_toggle = 1'b1;
              end else begin
                press_d = fbrc_pkg::CountSat;
              end
            end
          end
          do_sample = !do_toggle;
        end else begin
          tmr_d = tmr_q - TIMER_WIDTH'(1);
        end
      end
      fbrc_pkg::PH_PHOTO: begin
        if (last) begin
          do_drive = 1'b1;
        end else begin
          tmr_d = tmr_q - TIMER_WIDTH'(1);
        end
      end
      fbrc_pkg::PH_DRIVE: begin
        if (last) begin
          do_finish = 1'b1;
        end else begin
          tmr_d = tmr_q - TIMER_WIDTH'(1);
        end
      end
      default: begin
        do_sample = 1'b1;
      end
    endcase

    // Zero-length phases fall through to the next one within the same tick.
    if (do_toggle) begin
      pins_d.coupler_pin = 1'b1;
      tmr_d              = photo_ld;
      if (photo_ld == '0) begin
        do_drive = 1'b1;
      end else begin
        phase_d = fbrc_pkg::PH_PHOTO;
      end
    end

    if (do_drive) begin
      if (cfg_i.latching_relay) begin
        if (effect_q) begin
          pins_d.reset_pin = 1'b1;
          pins_d.led_pin   = 1'b0;
        end else begin
          pins_d.set_pin = 1'b1;
          pins_d.led_pin = 1'b1;
        end
      end else begin
        pins_d.hold_pin = !effect_q;
        pins_d.led_pin  = !effect_q;
      end
      tmr_d = pulse_ld;
      if (pulse_ld == '0) begin
        do_finish = 1'b1;
      end else begin
        phase_d = fbrc_pkg::PH_DRIVE;
      end
    end

    if (do_finish) begin
      pins_d.set_pin     = 1'b0;
      pins_d.reset_pin   = 1'b0;
      pins_d.coupler_pin = 1'b0;
      effect_d           = !effect_q;
      do_sample          = 1'b1;
    end

    if (do_sample) begin
      first_d = foot_i;
      tmr_d   = TIMER_WIDTH'(cfg_i.debounce_ticks);
      phase_d = fbrc_pkg::PH_WAIT;
    end

    res_o.pins = pins_d;
    res_o.busy = (phase_d == fbrc_pkg::PH_PHOTO) || (phase_d == fbrc_pkg::PH_DRIVE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= fbrc_pkg::PH_STARTUP;
      tmr_q    <= TIMER_WIDTH'(fbrc_pkg::PulseTicksRst);
      first_q  <= 1'b0;
      press_q  <= 2'd0;
      rel_q    <= fbrc_pkg::CountSat;
      effect_q <= 1'b0;
      pins_q   <= '{set_pin: 1'b0, reset_pin: 1'b1, hold_pin: 1'b0,
                    coupler_pin: 1'b0, led_pin: 1'b0};
    end else if (adv_i) begin
      phase_q  <= phase_d;
      tmr_q    <= tmr_d;
      first_q  <= first_d;
      press_q  <= press_d;
      rel_q    <= rel_d;
      effect_q <= effect_d;
      pins_q   <= pins_d;
    end
  end

`include "footswitch_bypass_relay_controller_core_assert.svh"

  `FBRC_ASSERT_NOW(a_coils_exclusive, clk_i, rst_ni, 1'b1, !(pins_q.set_pin && pins_q.reset_pin))
  `FBRC_ASSERT_NOW(a_wait_unmuted, clk_i, rst_ni, phase_q == fbrc_pkg::PH_WAIT, !pins_q.coupler_pin)
  `FBRC_ASSERT_NOW(a_drive_muted, clk_i, rst_ni, phase_q == fbrc_pkg::PH_DRIVE, pins_q.coupler_pin)

endmodule

FILE: rtl/core/fbrc_out_buf.sv
// Two-entry result buffer of the footswitch bypass relay controller core.
// Lets a new beat enter while an earlier result waits. Uses fbrc_pkg.
module fbrc_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fbrc_pkg::res_t data_i,
  output logic           room_o,
  output logic           valid_o,
  input  logic           ready_i,
  output fbrc_pkg::res_t data_o
);

  fbrc_pkg::res_t mem_q [2];
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q, cnt_d;
  logic           pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != 2'd0);
  assign room_o  = (cnt_q != 2'd2) || ready_i;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    case ({push_i, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q <= !rd_q;
      end
    end
  end

`include "footswitch_bypass_relay_controller_core_assert.svh"

  `FBRC_ASSERT_NOW(a_no_overflow, clk_i, rst_ni, push_i && cnt_q == 2'd2, pop)
  `FBRC_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, cnt_q != 2'd3)
  `FBRC_ASSERT_NEXT(a_push_seen, clk_i, rst_ni, push_i && !pop && cnt_q == 2'd0, valid_o)

endmodule

FILE: rtl/core/footswitch_bypass_relay_controller_core.sv
// Top level of the footswitch bypass relay controller core: ports, config
// registers, input register. Uses fbrc_pkg, fbrc_step and fbrc_out_buf.
//
//   channel   signals                                   role
//   input     in_valid_i / in_ready_o, foot/mode level  one tick per beat
//   output    out_valid_o / out_ready_i, pins and busy  one result per tick
//   config    cfg_valid_i / cfg_ready_o, index, data    register write
//
// A beat lands in the input register, then combinational logic updates the
// phase, timer and pins and writes the result into a two-entry buffer: one
// beat per cycle sustained while the buffer has room.
// Reset restarts in the startup pulse phase with default register values.
// A stalled output holds the buffer; input keeps flowing until it is full.
module footswitch_bypass_relay_controller_core #(
  parameter int unsigned TIMER_WIDTH = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 foot_level_i,
  input  logic                                 mode_level_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 relay_set_pin_o,
  output logic                                 relay_reset_pin_o,
  output logic                                 relay_hold_pin_o,
  output logic                                 coupler_pin_o,
  output logic                                 led_pin_o,
  output logic                                 busy_res_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [fbrc_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [fbrc_pkg::CfgW-1:0]            cfg_data_i
);

  fbrc_pkg::cfg_t cfg_q;
  logic           in_v_q;
  logic           foot_q, mode_q;
  logic           adv, buf_room;
  fbrc_pkg::res_t res_d, res_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{photo_ticks: fbrc_pkg::PhotoTicksRst,
                 pulse_ticks: fbrc_pkg::PulseTicksRst,
                 debounce_ticks: fbrc_pkg::DebounceTicksRst,
                 latching_relay: 1'b1};
    end else if (cfg_valid_i) begin
      case (fbrc_pkg::cfg_idx_e'(cfg_index_i))
        fbrc_pkg::CFG_PHOTO_TICKS:    cfg_q.photo_ticks    <= cfg_data_i;
        fbrc_pkg::CFG_PULSE_TICKS:    cfg_q.pulse_ticks    <= cfg_data_i;
        fbrc_pkg::CFG_DEBOUNCE_TICKS: cfg_q.debounce_ticks <= cfg_data_i;
        fbrc_pkg::CFG_LATCHING_RELAY: cfg_q.latching_relay <= cfg_data_i[0];
        default:                      cfg_q                <= cfg_q;
      endcase
    end
  end

  // Advance the held beat whenever the buffer can take its result.
  assign adv        = in_v_q && buf_room;
  assign in_ready_o = !in_v_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      foot_q <= foot_level_i;
      mode_q <= mode_level_i;
    end
  end

  fbrc_step #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_step (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .adv_i (adv),
    .foot_i(foot_q),
    .mode_i(mode_q),
    .cfg_i (cfg_q),
    .res_o (res_d)
  );

  fbrc_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (adv),
    .data_i (res_d),
    .room_o (buf_room),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .data_o (res_out)
  );

  assign relay_set_pin_o   = res_out.pins.set_pin;
  assign relay_reset_pin_o = res_out.pins.reset_pin;
  assign relay_hold_pin_o  = res_out.pins.hold_pin;
  assign coupler_pin_o     = res_out.pins.coupler_pin;
  assign led_pin_o         = res_out.pins.led_pin;
  assign busy_res_o        = res_out.busy;

endmodule
